FILE: hw/rtl/rsame_pkg.sv
package rsame_pkg;

    // Default modulus width of the datapath.
    localparam int MOD_BITS_DEF = 32;

    // Width of the register port, the value field and the result field.
    localparam int WORD_W = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PUB_EXP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP = 2'd2;

    // Register values after reset.
    localparam logic [WORD_W-1:0] RST_MODULUS  = 32'd2;
    localparam logic [WORD_W-1:0] RST_PUB_EXP  = 32'd65537;
    localparam logic [WORD_W-1:0] RST_PRIV_EXP = 32'd1;

    // Command codes.
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // A message or a recovered plaintext is one byte.
    localparam logic [WORD_W-1:0] BYTE_MASK = 32'h0000_00FF;

endpackage

FILE: hw/rtl/rsame_modmul.sv
module rsame_modmul #(
    parameter int MOD_BITS = rsame_pkg::MOD_BITS_DEF,
    parameter int B_BITS   = rsame_pkg::WORD_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MOD_BITS-1:0] i_a,
    input  logic [B_BITS-1:0]   i_b,
    input  logic [MOD_BITS-1:0] i_m,
    output logic                o_busy,
    output logic                o_done,
    output logic [MOD_BITS-1:0] o_p
);
    import rsame_pkg::*;

    localparam int CNT_W = $clog2(B_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [MOD_BITS-1:0] r_acc;
    logic [MOD_BITS-1:0] r_a;
    logic [B_BITS-1:0]   r_b;

    logic [MOD_BITS:0]   w_dbl;
    logic [MOD_BITS:0]   w_sum;
    logic [MOD_BITS:0]   w_m_ext;
    logic [MOD_BITS-1:0] w_half;
    logic [MOD_BITS-1:0] w_next;

    // One bit of the multiplier per cycle, most significant first: the
    // accumulator is doubled modulo m, then the multiplicand is added modulo m
    // when the bit is set. Both operands stay below m, so one conditional
    // subtraction suffices after each addition.
    always_comb begin
        w_m_ext = {1'b0, i_m};
        w_dbl   = {r_acc, 1'b0};
        if (w_dbl >= w_m_ext) begin
            w_half = MOD_BITS'(w_dbl - w_m_ext);
        end else begin
            w_half = MOD_BITS'(w_dbl);
        end
        w_sum = {1'b0, w_half} + {1'b0, r_a};
        if (!r_b[B_BITS-1]) begin
            w_next = w_half;
        end else if (w_sum >= w_m_ext) begin
            w_next = MOD_BITS'(w_sum - w_m_ext);
        end else begin
            w_next = MOD_BITS'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(B_BITS);
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
            end else if (r_busy) begin
                r_acc <= w_next;
                r_b   <= {r_b[B_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_p    = r_acc;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("multiplication started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("done pulse without a finished multiplication");

    a_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("bit counter ran out while busy");

endmodule

FILE: hw/rtl/rsa_modular_exponentiation_top.sv
// Channel  | Handshake                    | Payload
// ---------+------------------------------+----------------------------------
// in       | i_in_valid / o_in_ready      | i_cmd, i_value
// out      | o_out_valid / i_out_ready    | o_result
// config   | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// One item is in work at a time. With B = max(MOD_BITS, 32), each modular
// multiplication is one B-bit pass of the shared bit-serial multiplier, and
// the base reduction takes one more such pass. For an exponent of bit length L
// with H set bits an item then needs H multiplications and L - 1 squarings.
// Exponent zero or modulus zero skips the multiplier and goes straight to
// the finishing state. Reset is synchronous and active low; it restores the
// registers. A finished result waits in the output register; the next item
// is taken while it waits, and the block only stalls a further result on it.
module rsa_modular_exponentiation_top #(
    parameter int MOD_BITS = rsame_pkg::MOD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rsame_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rsame_pkg::WORD_W-1:0]     i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_cmd,
    input  logic [rsame_pkg::WORD_W-1:0]     i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [rsame_pkg::WORD_W-1:0]     o_result
);
    import rsame_pkg::*;

    // The multiplier bit count also has to cover a full 32-bit value for the
    // initial reduction of the base.
    localparam int B_BITS = (MOD_BITS > WORD_W) ? MOD_BITS : WORD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_STEP,
        S_MUL,
        S_SQR,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [WORD_W-1:0]   r_modulus;
    logic [WORD_W-1:0]   r_pub_exp;
    logic [WORD_W-1:0]   r_priv_exp;
    logic                r_cmd;
    logic [WORD_W-1:0]   r_value;
    logic [WORD_W-1:0]   r_exp;
    logic [MOD_BITS-1:0] r_m;
    logic [MOD_BITS-1:0] r_acc;
    logic [MOD_BITS-1:0] r_base;
    logic                r_go;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_result;

    logic [MOD_BITS-1:0] w_m;
    logic [WORD_W-1:0]   w_exp;
    logic [WORD_W-1:0]   w_res;
    logic [MOD_BITS-1:0] w_a;
    logic [B_BITS-1:0]   w_b;
    logic                w_busy;
    logic                w_done;
    logic [MOD_BITS-1:0] w_p;
    logic                w_accept;

    // Only the low MOD_BITS bits of the modulus register take part.
    assign w_m      = MOD_BITS'(r_modulus);
    assign w_exp    = (i_cmd == CMD_DECRYPT) ? r_priv_exp : r_pub_exp;
    assign w_res    = WORD_W'(r_acc);
    assign w_accept = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= RST_MODULUS;
            r_pub_exp  <= RST_PUB_EXP;
            r_priv_exp <= RST_PRIV_EXP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODULUS:  r_modulus  <= i_cfg_data;
                CFG_PUB_EXP:  r_pub_exp  <= i_cfg_data;
                CFG_PRIV_EXP: r_priv_exp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Operands for the shared multiplier. The base reduction multiplies one
    // by the full value word; the multiply step takes acc * base and the
    // square step base * base.
    always_comb begin
        case (r_state)
            S_RED: begin
                w_a = MOD_BITS'(1);
                w_b = B_BITS'(r_value);
            end
            S_SQR: begin
                w_a = r_base;
                w_b = B_BITS'(r_base);
            end
            default: begin
                w_a = r_acc;
                w_b = B_BITS'(r_base);
            end
        endcase
    end

    rsame_modmul #(
        .MOD_BITS (MOD_BITS),
        .B_BITS   (B_BITS)
    ) u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_m     (r_m),
        .o_busy  (w_busy),
        .o_done  (w_done),
        .o_p     (w_p)
    );

    // Right-to-left square and multiply. The exponent shifts down by one bit
    // per step; the loop ends after the multiply for the top set bit, so the
    // last, unused squaring is skipped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_go <= 1'b0;
            // In the finishing state the output register is handled below.
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd <= i_cmd;
                        r_exp <= w_exp;
                        r_m   <= w_m;
                        if (i_cmd == CMD_DECRYPT) begin
                            r_value <= i_value;
                        end else begin
                            r_value <= i_value & BYTE_MASK;
                        end
                        if (w_exp == '0) begin
                            // Anything to the power zero is one, even mod one.
                            r_acc   <= MOD_BITS'(1);
                            r_state <= S_DONE;
                        end else if (w_m == '0) begin
                            r_acc   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_go    <= 1'b1;
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (w_done) begin
                        r_base  <= w_p;
                        r_acc   <= (r_m == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    r_go <= 1'b1;
                    if (r_exp[0]) begin
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_SQR;
                    end
                end
                S_MUL: begin
                    if (w_done) begin
                        r_acc <= w_p;
                        if (r_exp[WORD_W-1:1] == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_go    <= 1'b1;
                            r_state <= S_SQR;
                        end
                    end
                end
                S_SQR: begin
                    if (w_done) begin
                        r_base  <= w_p;
                        r_exp   <= {1'b0, r_exp[WORD_W-1:1]};
                        r_state <= S_STEP;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        if (r_cmd == CMD_DECRYPT) begin
                            r_result <= w_res & BYTE_MASK;
                        end else begin
                            r_result <= w_res;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    a_accept_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !w_busy && !r_go)
        else $error("item accepted while the multiplier is in use");

    a_step_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_acc < r_m) && (r_base < r_m) && (r_exp != '0))
        else $error("exponent step with operands out of range");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared outside the finishing state");

endmodule
